[src/ewkc_pkg.sv]
`default_nettype none
package ewkc_pkg;

    localparam logic [4:0]  MAX_NONCE_BYTES = 5'd16;
    localparam logic [15:0] RETENTION_RESET = 16'd300;
    localparam logic [31:0] SECONDS_MAX     = 32'hFFFF_FFFF;
    localparam logic [0:0]  REG_RETENTION   = 1'b0;

    typedef enum logic [1:0] {
        ACT_ADD     = 2'd0,
        ACT_FIND    = 2'd1,
        ACT_CLEANUP = 2'd2,
        ACT_TICK    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_FOUND  = 2'd1,
        STAT_NONCE_LONG = 2'd2,
        STAT_FULL       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_CL_RD,
        S_CL_CHK,
        S_CL_MV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [255:0] key;
        logic [255:0] orig;
        logic [127:0] nonce;
        logic [4:0]   nonce_len;
        logic [31:0]  expiry;
    } entry_t;

    // keep the low n bytes of w; eight or more keeps all of it
    function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [4:0] n);
        logic [63:0] mask;
        mask = ~(64'hFFFF_FFFF_FFFF_FFFF << {n[2:0], 3'b000});
        if (n >= 5'd8)
            keep_bytes = w;
        else
            keep_bytes = w & mask;
    endfunction

endpackage
`default_nettype wire

[src/ewkc_if.sv]
`default_nettype none
interface ewkc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [63:0] key_word0;
    logic [63:0] key_word1;
    logic [63:0] key_word2;
    logic [63:0] key_word3;
    logic [63:0] orig_word0;
    logic [63:0] orig_word1;
    logic [63:0] orig_word2;
    logic [63:0] orig_word3;
    logic [4:0]  nonce_length;
    logic [63:0] nonce_low;
    logic [63:0] nonce_high;

    modport source (
        output valid, action, key_word0, key_word1, key_word2, key_word3,
               orig_word0, orig_word1, orig_word2, orig_word3,
               nonce_length, nonce_low, nonce_high,
        input  ready
    );
    modport sink (
        input  valid, action, key_word0, key_word1, key_word2, key_word3,
               orig_word0, orig_word1, orig_word2, orig_word3,
               nonce_length, nonce_low, nonce_high,
        output ready
    );
endinterface

interface ewkc_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] found_orig0;
    logic [63:0] found_orig1;
    logic [63:0] found_orig2;
    logic [63:0] found_orig3;
    logic [4:0]  found_nonce_length;
    logic [63:0] found_nonce_low;
    logic [63:0] found_nonce_high;
    logic [4:0]  entries_used;

    modport source (
        output valid, status, found_orig0, found_orig1, found_orig2, found_orig3,
               found_nonce_length, found_nonce_low, found_nonce_high, entries_used,
        input  ready
    );
    modport sink (
        input  valid, status, found_orig0, found_orig1, found_orig2, found_orig3,
               found_nonce_length, found_nonce_low, found_nonce_high, entries_used,
        output ready
    );
endinterface
`default_nettype wire

[src/ewkc_entry_ram.sv]
`default_nettype none
module ewkc_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire ewkc_pkg::entry_t wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output ewkc_pkg::entry_t      rd_data
);

    ewkc_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[src/expiring_work_key_cache.sv]
// Add and tick go from acceptance to the done state. Find reads and checks
// each scanned entry, with a final read state on a miss. Cleanup also moves
// the last entry into the hole of a removed non-last one. One transaction at
// a time; the single RAM read port sets the read-then-check step of scans.
// Reset clears the entry count, the seconds counter and control state and
// loads 300 into retention; the entry RAM holds its contents.
`default_nettype none
module expiring_work_key_cache #(
    parameter int CAPACITY = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ewkc_req_if.sink          req,
    ewkc_rsp_if.source        rsp,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ewkc_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    idx_reg;
    logic [31:0]      now_reg;
    logic [15:0]      retention_reg;
    logic [255:0]     key_reg;
    logic [1:0]       status_reg;
    logic             hit_reg;
    ewkc_pkg::entry_t found_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [255:0]     out_orig_reg;
    logic [4:0]       out_nlen_reg;
    logic [127:0]     out_nonce_reg;
    logic [4:0]       out_used_reg;

    ewkc_pkg::entry_t rd_data, wr_data, add_entry;
    logic             rd_en, wr_en, wr_sel_move;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             idx_inc, cnt_dec, hit_set, load_out;

    logic             accept, out_free, in_range, key_match, expired;
    logic [CW-1:0]    last;
    logic [32:0]      exp_sum;
    logic [1:0]       add_status;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ewkc_pkg::S_IDLE);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_range  = idx_reg < count_reg;
    assign last      = count_reg - CW'(1);
    assign key_match = (rd_data.key == key_reg);
    assign expired   = (now_reg >= rd_data.expiry);
    assign exp_sum   = {1'b0, now_reg} + {17'd0, retention_reg};

    always_comb
    begin
        if (req.nonce_length > ewkc_pkg::MAX_NONCE_BYTES)
            add_status = ewkc_pkg::STAT_NONCE_LONG;
        else if (count_reg >= CW'(CAPACITY))
            add_status = ewkc_pkg::STAT_FULL;
        else
            add_status = ewkc_pkg::STAT_OK;
    end

    always_comb
    begin
        add_entry.key         = {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
        add_entry.orig        = {req.orig_word3, req.orig_word2, req.orig_word1,
                                 req.orig_word0};
        add_entry.nonce[63:0] = ewkc_pkg::keep_bytes(req.nonce_low, req.nonce_length);
        add_entry.nonce[127:64] = (req.nonce_length > 5'd8)
            ? ewkc_pkg::keep_bytes(req.nonce_high, req.nonce_length - 5'd8) : 64'd0;
        add_entry.nonce_len   = req.nonce_length;
        add_entry.expiry      = exp_sum[32] ? ewkc_pkg::SECONDS_MAX : exp_sum[31:0];
    end

    assign wr_data = wr_sel_move ? rd_data : add_entry;

    ewkc_entry_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ewkc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (ewkc_pkg::action_t'(req.action))
                        ewkc_pkg::ACT_FIND:    state_next = ewkc_pkg::S_FIND_RD;
                        ewkc_pkg::ACT_CLEANUP: state_next = ewkc_pkg::S_CL_RD;
                        default:               state_next = ewkc_pkg::S_DONE;
                    endcase
                end
            end
            ewkc_pkg::S_FIND_RD:
                state_next = in_range ? ewkc_pkg::S_FIND_CHK : ewkc_pkg::S_DONE;
            ewkc_pkg::S_FIND_CHK:
                state_next = key_match ? ewkc_pkg::S_DONE : ewkc_pkg::S_FIND_RD;
            ewkc_pkg::S_CL_RD:
                state_next = in_range ? ewkc_pkg::S_CL_CHK : ewkc_pkg::S_DONE;
            ewkc_pkg::S_CL_CHK:
                state_next = (expired && last != idx_reg) ? ewkc_pkg::S_CL_MV
                                                          : ewkc_pkg::S_CL_RD;
            ewkc_pkg::S_CL_MV:
                state_next = ewkc_pkg::S_CL_RD;
            ewkc_pkg::S_DONE:
                state_next = out_free ? ewkc_pkg::S_IDLE : ewkc_pkg::S_DONE;
            default:
                state_next = ewkc_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        rd_en       = 1'b0;
        rd_addr     = idx_reg[AW-1:0];
        wr_en       = 1'b0;
        wr_addr     = count_reg[AW-1:0];
        wr_sel_move = 1'b0;
        idx_inc     = 1'b0;
        cnt_dec     = 1'b0;
        hit_set     = 1'b0;
        load_out    = 1'b0;
        case (state_reg)
            ewkc_pkg::S_IDLE:
                wr_en = accept && (req.action == ewkc_pkg::ACT_ADD)
                        && (add_status == ewkc_pkg::STAT_OK);
            ewkc_pkg::S_FIND_RD,
            ewkc_pkg::S_CL_RD:
                rd_en = in_range;
            ewkc_pkg::S_FIND_CHK:
            begin
                hit_set = key_match;
                idx_inc = !key_match;
            end
            ewkc_pkg::S_CL_CHK:
            begin
                if (expired)
                begin
                    cnt_dec = 1'b1;
                    // fetch the last entry to fill the hole
                    rd_en   = (last != idx_reg);
                    rd_addr = last[AW-1:0];
                end
                else
                    idx_inc = 1'b1;
            end
            ewkc_pkg::S_CL_MV:
            begin
                wr_en       = 1'b1;
                wr_addr     = idx_reg[AW-1:0];
                wr_sel_move = 1'b1;
            end
            ewkc_pkg::S_DONE:
                load_out = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ewkc_pkg::S_IDLE;
            count_reg     <= '0;
            now_reg       <= '0;
            retention_reg <= ewkc_pkg::RETENTION_RESET;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && pready && paddr[2] == ewkc_pkg::REG_RETENTION)
                retention_reg <= pwdata[15:0];
            if (accept)
            begin
                idx_reg <= '0;
                hit_reg <= 1'b0;
                if (req.action == ewkc_pkg::ACT_ADD && add_status == ewkc_pkg::STAT_OK)
                    count_reg <= count_reg + CW'(1);
                if (req.action == ewkc_pkg::ACT_TICK && now_reg != ewkc_pkg::SECONDS_MAX)
                    now_reg <= now_reg + 32'd1;
            end
            if (idx_inc)
                idx_reg <= idx_reg + CW'(1);
            if (cnt_dec)
                count_reg <= last;
            if (hit_set)
                hit_reg <= 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= {req.key_word3, req.key_word2, req.key_word1, req.key_word0};
            case (ewkc_pkg::action_t'(req.action))
                ewkc_pkg::ACT_ADD:  status_reg <= add_status;
                ewkc_pkg::ACT_FIND: status_reg <= ewkc_pkg::STAT_NOT_FOUND;
                default:            status_reg <= ewkc_pkg::STAT_OK;
            endcase
        end
        if (hit_set)
        begin
            found_reg  <= rd_data;
            status_reg <= ewkc_pkg::STAT_OK;
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_orig_reg   <= hit_reg ? found_reg.orig : 256'd0;
            out_nlen_reg   <= hit_reg ? found_reg.nonce_len : 5'd0;
            out_nonce_reg  <= hit_reg ? found_reg.nonce : 128'd0;
            out_used_reg   <= 5'(count_reg);
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.found_orig0        = out_orig_reg[63:0];
    assign rsp.found_orig1        = out_orig_reg[127:64];
    assign rsp.found_orig2        = out_orig_reg[191:128];
    assign rsp.found_orig3        = out_orig_reg[255:192];
    assign rsp.found_nonce_length = out_nlen_reg;
    assign rsp.found_nonce_low    = out_nonce_reg[63:0];
    assign rsp.found_nonce_high   = out_nonce_reg[127:64];
    assign rsp.entries_used       = out_used_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ewkc_pkg::REG_RETENTION) ? {16'd0, retention_reg} : 32'd0;

endmodule
`default_nettype wire
